FILE: design/dnms_pkg.sv
`default_nettype none
package dnms_pkg;

    localparam int MAX_DETECTIONS = 64;
    localparam int COUNT_W        = $clog2(MAX_DETECTIONS + 1);
    localparam int RANGE_W        = 8;
    localparam int DOPPLER_W      = 7;
    localparam int MAG_W          = 32;
    localparam int SEP_W          = 8;
    localparam logic [SEP_W-1:0] MIN_SEP_RESET = 8'd3;

    typedef struct packed {
        logic [RANGE_W-1:0]   rng;
        logic [DOPPLER_W-1:0] dop;
        logic [MAG_W-1:0]     mag;
    } det_t;

    typedef struct packed {
        logic valid;
        logic supp;
        det_t det;
    } slot_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage
`default_nettype wire

FILE: design/dnms_cell.sv
`default_nettype none
module dnms_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       insert,
    input  wire logic                       shift,
    input  wire dnms_pkg::det_t             new_det,
    input  wire logic                       left_ge,
    input  wire dnms_pkg::slot_t            left_slot,
    input  wire dnms_pkg::slot_t            right_slot,
    input  wire dnms_pkg::det_t             peak_det,
    input  wire logic                       peak_live,
    input  wire logic [dnms_pkg::SEP_W-1:0] min_sep,
    output dnms_pkg::slot_t                 slot,
    output logic                            ge,
    output dnms_pkg::slot_t                 shift_out
);

    dnms_pkg::slot_t slot_reg;
    dnms_pkg::slot_t slot_next;
    logic [dnms_pkg::RANGE_W-1:0] d_rng;
    logic [dnms_pkg::SEP_W-1:0]   d_dop;
    logic                         hit;

    assign ge = slot_reg.valid && (slot_reg.det.mag >= new_det.mag);

    // Only a live peak suppresses its neighbors.
    always_comb
    begin
        d_rng = (slot_reg.det.rng >= peak_det.rng) ? slot_reg.det.rng - peak_det.rng
                                                   : peak_det.rng - slot_reg.det.rng;
        d_dop = (slot_reg.det.dop >= peak_det.dop)
              ? dnms_pkg::SEP_W'(slot_reg.det.dop - peak_det.dop)
              : dnms_pkg::SEP_W'(peak_det.dop - slot_reg.det.dop);
        hit   = peak_live && (d_rng <= min_sep) && (d_dop <= min_sep);
    end

    always_comb
    begin
        shift_out       = slot_reg;
        shift_out.supp  = slot_reg.supp | hit;
        slot_next       = slot_reg;
        if (insert && !ge)
        begin
            if (left_ge)
            begin
                slot_next.valid = 1'b1;
                slot_next.supp  = 1'b0;
                slot_next.det   = new_det;
            end
            else
            begin
                slot_next = left_slot;
            end
        end
        else if (shift)
        begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule
`default_nettype wire

FILE: design/detection_non_max_suppression_unit.sv
`default_nettype none
// Greedy non-maximum suppression of radar detections.
//
// Input channel: an item (range_index, doppler_index, magnitude, last_in)
// is taken at a clock edge with start high and busy low. Detections load
// one per cycle into a row of cells that keeps them sorted by descending
// magnitude; equal magnitudes keep arrival order. Items beyond 64 held
// detections are dropped and flag every peak of that run via overflowed.
// The item marked last raises busy; the row then shifts toward cell 0 one
// detection per cycle. An unsuppressed head is a peak and marks every cell
// within min_separation on both axes. Busy stays high until the row has
// emptied after the last item; one result appears per peak,
// one cycle each on result_valid, with last_out on the final peak.
// Results cannot be stalled: the receiver must take each when shown.
// Config: cfg_data is written when cfg_valid is high (cfg_ready always
// high); write only while idle. Reset clears the row, count, drop flag
// and sets min_separation to 3.
module detection_non_max_suppression_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dnms_pkg::RANGE_W-1:0]  range_index,
    input  wire logic [dnms_pkg::DOPPLER_W-1:0] doppler_index,
    input  wire logic [dnms_pkg::MAG_W-1:0]    magnitude,
    input  wire logic                          last_in,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dnms_pkg::SEP_W-1:0]    cfg_data,
    output logic                               result_valid,
    output logic [dnms_pkg::RANGE_W-1:0]       peak_range,
    output logic [dnms_pkg::DOPPLER_W-1:0]     peak_doppler,
    output logic [dnms_pkg::MAG_W-1:0]         peak_magnitude,
    output logic                               last_out,
    output logic                               overflowed
);

    localparam int N = dnms_pkg::MAX_DETECTIONS;

    dnms_pkg::state_t state_reg, state_next;
    logic [dnms_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         drop_reg, drop_next;
    logic [dnms_pkg::SEP_W-1:0]   sep_reg;
    logic                         pend_valid_reg, pend_valid_next;
    dnms_pkg::det_t               pend_reg, pend_next;
    logic                         rv_reg, rv_next, lo_reg, lo_next, ov_reg, ov_next;
    dnms_pkg::det_t               out_reg, out_next;

    dnms_pkg::slot_t slots [N];
    dnms_pkg::slot_t souts [N];
    logic [N-1:0]    ges;
    dnms_pkg::det_t  new_det;
    logic            accept, insert, shift, full;
    logic            head_live;
    dnms_pkg::slot_t head;
    dnms_pkg::slot_t empty_slot;

    assign busy      = (state_reg == dnms_pkg::ST_SCAN);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign full      = (count_reg == dnms_pkg::COUNT_W'(N));
    assign insert    = accept && !full;
    assign head      = slots[0];
    assign shift     = busy && head.valid;
    assign head_live = shift && !head.supp;
    assign new_det   = '{rng: range_index, dop: doppler_index, mag: magnitude};

    always_comb
    begin
        empty_slot       = '0;
    end

    // Row of cells: cell 0 holds the strongest detection.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        dnms_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .insert     (insert),
            .shift      (shift),
            .new_det    (new_det),
            .left_ge    ((i == 0) ? 1'b1 : ges[(i == 0) ? 0 : i-1]),
            .left_slot  ((i == 0) ? empty_slot : slots[(i == 0) ? 0 : i-1]),
            .right_slot ((i == N-1) ? empty_slot : souts[(i == N-1) ? 0 : i+1]),
            .peak_det   (head.det),
            .peak_live  (head_live),
            .min_sep    (sep_reg),
            .slot       (slots[i]),
            .ge         (ges[i]),
            .shift_out  (souts[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rv_next         = 1'b0;
        lo_next         = 1'b0;
        ov_next         = ov_reg;
        out_next        = out_reg;
        case (state_reg)
            dnms_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                        drop_next = 1'b1;
                    else
                        count_next = count_reg + 1'b1;
                    if (last_in)
                        state_next = dnms_pkg::ST_SCAN;
                end
            end
            dnms_pkg::ST_SCAN:
            begin
                if (head.valid)
                begin
                    // Hold each peak until the next one shows up, so the
                    // final one can be marked.
                    if (!head.supp)
                    begin
                        if (pend_valid_reg)
                        begin
                            rv_next  = 1'b1;
                            out_next = pend_reg;
                            ov_next  = drop_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = head.det;
                    end
                end
                else
                begin
                    rv_next         = 1'b1;
                    lo_next         = 1'b1;
                    out_next        = pend_reg;
                    ov_next         = drop_reg;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    drop_next       = 1'b0;
                    state_next      = dnms_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = dnms_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dnms_pkg::ST_LOAD;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            sep_reg        <= dnms_pkg::MIN_SEP_RESET;
            pend_valid_reg <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            drop_reg       <= drop_next;
            pend_valid_reg <= pend_valid_next;
            rv_reg         <= rv_next;
            if (cfg_valid && cfg_ready)
                sep_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        lo_reg   <= lo_next;
        ov_reg   <= ov_next;
    end

    assign result_valid   = rv_reg;
    assign peak_range     = out_reg.rng;
    assign peak_doppler   = out_reg.dop;
    assign peak_magnitude = out_reg.mag;
    assign last_out       = rv_reg && lo_reg;
    assign overflowed     = ov_reg;

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_out |-> !busy)
        else $error("final peak shown while still scanning");
    a_idle_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !busy |-> last_out)
        else $error("non-final peak shown after scan ended");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dnms_pkg::COUNT_W'(N))
        else $error("detection count beyond capacity");

endmodule
`default_nettype wire
